// ===== rtl/mtss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtss_pkg;

	// Port widths; the stream data payloads are padded to whole bytes
	localparam int IN_DATA_W  = 136;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 72;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Item modes
	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_STEP  = 3'd1;
	localparam logic [2:0] MODE_RAMP  = 3'd2;
	localparam logic [2:0] MODE_BIAS  = 3'd3;
	localparam logic [2:0] MODE_STOP  = 3'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_START = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_INC   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESH = 3'd5;

	// Motor selection codes
	localparam logic [1:0] SEL_BOTH  = 2'd0;
	localparam logic [1:0] SEL_LEFT  = 2'd1;
	localparam logic [1:0] SEL_RIGHT = 2'd2;

	// Argument limits of a test start
	localparam logic [15:0] STEP_MAX_TICKS = 16'd10000;
	localparam logic [15:0] RAMP_MIN_TICKS = 16'd50;
	localparam logic [15:0] RAMP_MAX_TICKS = 16'd5000;

	// Register reset values
	localparam logic [14:0] RST_DRIVE_LIMIT = 15'd8000;
	localparam logic [14:0] RST_PROBE_START = 15'd2000;
	localparam logic [14:0] RST_PROBE_INC   = 15'd100;
	localparam logic [14:0] RST_PROBE_MAX   = 15'd7000;
	localparam logic [15:0] RST_SETTLE      = 16'd300;
	localparam logic [15:0] RST_MOVE_THRESH = 16'd40;

	typedef enum logic [3:0] {
		KIND_IDLE = 4'b0001,
		KIND_STEP = 4'b0010,
		KIND_RAMP = 4'b0100,
		KIND_BIAS = 4'b1000
	} kind_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [15:0] level_mv;
		logic signed [15:0] end_mv;
		logic signed [15:0] increment_mv;
		logic [15:0]        span_ticks;
		logic [7:0]         motor_choice;
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} item_t;

	typedef struct packed {
		logic [14:0] drive_limit_mv;
		logic [14:0] probe_start_mv;
		logic [14:0] probe_increment_mv;
		logic [14:0] probe_max_mv;
		logic [15:0] probe_settle_ticks;
		logic [15:0] move_threshold;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] left_drive_mv;
		logic signed [15:0] right_drive_mv;
		logic               active;
		logic               status;
		logic               clear_counts;
		logic signed [15:0] bias_left_mv;
		logic signed [15:0] bias_right_mv;
	} result_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
	} drive_pair_t;

	// Route one level to the selected motors, zero to the other
	function automatic drive_pair_t drive_split(input logic [1:0] sel,
			input logic signed [15:0] mv);
		drive_pair_t d;
		case (sel)
			SEL_LEFT: begin
				d.left  = mv;
				d.right = '0;
			end
			SEL_RIGHT: begin
				d.left  = '0;
				d.right = mv;
			end
			default: begin
				d.left  = mv;
				d.right = mv;
			end
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/mtss_move_det.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtss_move_det #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic [COUNT_BITS-1:0] now_cnt,
	input  wire logic [COUNT_BITS-1:0] base_cnt,
	input  wire logic [15:0]           threshold,
	output logic                       moved
);

	logic [COUNT_BITS-1:0] diff;
	logic [COUNT_BITS-1:0] mag;

	// Wrapping difference read as signed; the most negative value keeps its magnitude
	assign diff  = now_cnt - base_cnt;
	assign mag   = diff[COUNT_BITS-1] ? (~diff + COUNT_BITS'(1)) : diff;
	assign moved = (mag >= COUNT_BITS'(threshold));

endmodule

`default_nettype wire

// ===== rtl/mtss_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtss_engine #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire mtss_pkg::item_t  item,
	input  wire mtss_pkg::cfg_t   cfg,
	output mtss_pkg::result_t     res
);

	import mtss_pkg::*;

	kind_t                   kind_q, kind_nxt;
	logic [1:0]              sel_q, sel_nxt;
	logic signed [15:0]      step_level_q, step_level_nxt;
	logic [13:0]             step_rem_q, step_rem_nxt;
	logic signed [17:0]      ramp_level_q, ramp_level_nxt;
	logic signed [15:0]      ramp_end_q, ramp_end_nxt;
	logic signed [15:0]      ramp_inc_q, ramp_inc_nxt;
	logic [12:0]             ramp_period_q, ramp_period_nxt;
	logic [12:0]             ramp_elapsed_q, ramp_elapsed_nxt;
	logic [15:0]             probe_q, probe_nxt;
	logic [15:0]             settle_q, settle_nxt;
	logic [COUNT_BITS-1:0]   base_q, base_nxt;
	logic                    phase_q, phase_nxt;
	logic signed [15:0]      found_l_q, found_l_nxt;
	logic signed [15:0]      found_r_q, found_r_nxt;
	drive_pair_t             held_q, held_nxt;

	logic                    status;
	logic                    clr;
	logic                    enter_left;
	logic                    enter_right;
	logic                    go_idle;

	logic signed [16:0]      lim_p, lim_n, lvl17, end17;
	logic                    step_bad, ramp_bad;
	logic signed [15:0]      inc_fix;
	logic [1:0]              choice_sel;
	logic [12:0]             el_inc;
	logic signed [17:0]      ramp_sum, end18;
	logic                    ramp_past;
	logic [15:0]             probe_sum;
	logic [COUNT_BITS-1:0]   now_cnt;
	logic                    moved;

	assign lim_p = signed'({2'b00, cfg.drive_limit_mv});
	assign lim_n = -lim_p;
	assign lvl17 = {item.level_mv[15], item.level_mv};
	assign end17 = {item.end_mv[15], item.end_mv};

	assign step_bad = (item.span_ticks == '0) || (item.span_ticks > STEP_MAX_TICKS) ||
		(lvl17 < lim_n) || (lvl17 > lim_p);
	assign ramp_bad = (item.increment_mv == '0) || (item.span_ticks < RAMP_MIN_TICKS) ||
		(item.span_ticks > RAMP_MAX_TICKS) || (lvl17 < lim_n) || (lvl17 > lim_p) ||
		(end17 < lim_n) || (end17 > lim_p);

	// Point the increment towards the end level; saturate the one value with no negation
	always_comb begin
		inc_fix = item.increment_mv;
		if ((item.level_mv < item.end_mv && item.increment_mv < 0) ||
				(item.level_mv > item.end_mv && item.increment_mv > 0)) begin
			inc_fix = (item.increment_mv == 16'sh8000) ? 16'sh7fff : -item.increment_mv;
		end
	end

	assign choice_sel = (item.motor_choice > 8'd2) ? SEL_BOTH : item.motor_choice[1:0];

	assign el_inc    = ramp_elapsed_q + 13'd1;
	assign ramp_sum  = ramp_level_q + {{2{ramp_inc_q[15]}}, ramp_inc_q};
	assign end18     = {{2{ramp_end_q[15]}}, ramp_end_q};
	assign ramp_past = ((ramp_inc_q > 0) && (ramp_sum > end18)) ||
		((ramp_inc_q < 0) && (ramp_sum < end18));

	assign probe_sum = probe_q + {1'b0, cfg.probe_increment_mv};
	assign now_cnt   = phase_q ? item.right_count[COUNT_BITS-1:0] :
		item.left_count[COUNT_BITS-1:0];

	mtss_move_det #(
		.COUNT_BITS(COUNT_BITS)
	) u_move_det (
		.now_cnt  (now_cnt),
		.base_cnt (base_q),
		.threshold(cfg.move_threshold),
		.moved    (moved)
	);

	always_comb begin
		kind_nxt         = kind_q;
		sel_nxt          = sel_q;
		step_level_nxt   = step_level_q;
		step_rem_nxt     = step_rem_q;
		ramp_level_nxt   = ramp_level_q;
		ramp_end_nxt     = ramp_end_q;
		ramp_inc_nxt     = ramp_inc_q;
		ramp_period_nxt  = ramp_period_q;
		ramp_elapsed_nxt = ramp_elapsed_q;
		probe_nxt        = probe_q;
		settle_nxt       = settle_q;
		base_nxt         = base_q;
		phase_nxt        = phase_q;
		found_l_nxt      = found_l_q;
		found_r_nxt      = found_r_q;
		held_nxt         = held_q;
		status           = 1'b0;
		clr              = 1'b0;
		enter_left       = 1'b0;
		enter_right      = 1'b0;
		go_idle          = 1'b0;

		case (item.mode)
			MODE_TICK: begin
				case (kind_q)
					KIND_STEP: begin
						if (step_rem_q != '0) begin
							step_rem_nxt = step_rem_q - 14'd1;
							held_nxt     = drive_split(sel_q, step_level_q);
						end else begin
							go_idle = 1'b1;
						end
					end
					KIND_RAMP: begin
						if (el_inc >= ramp_period_q) begin
							ramp_elapsed_nxt = '0;
							ramp_level_nxt   = ramp_sum;
							if (ramp_past) begin
								go_idle = 1'b1;
							end else begin
								held_nxt = drive_split(sel_q, ramp_sum[15:0]);
							end
						end else begin
							ramp_elapsed_nxt = el_inc;
							held_nxt         = drive_split(sel_q, ramp_level_q[15:0]);
						end
					end
					KIND_BIAS: begin
						if (settle_q != '0) begin
							settle_nxt = settle_q - 16'd1;
							held_nxt   = drive_split(sel_q, signed'(probe_q));
						end else if (moved) begin
							if (!phase_q) begin
								found_l_nxt = signed'(probe_q);
								enter_right = 1'b1;
							end else begin
								found_r_nxt = signed'(probe_q);
								go_idle     = 1'b1;
							end
						end else if (probe_sum > {1'b0, cfg.probe_max_mv}) begin
							if (!phase_q) begin
								found_l_nxt = -16'sd1;
								enter_right = 1'b1;
							end else begin
								found_r_nxt = -16'sd1;
								go_idle     = 1'b1;
							end
						end else begin
							probe_nxt  = probe_sum;
							settle_nxt = cfg.probe_settle_ticks;
							base_nxt   = now_cnt;
							held_nxt   = drive_split(sel_q, signed'(probe_sum));
						end
					end
					default: begin
						go_idle = 1'b1;
					end
				endcase
			end
			MODE_STEP: begin
				if (step_bad) begin
					status = 1'b1;
				end else begin
					kind_nxt       = KIND_STEP;
					step_level_nxt = item.level_mv;
					step_rem_nxt   = item.span_ticks[13:0];
					sel_nxt        = choice_sel;
					held_nxt       = drive_split(choice_sel, item.level_mv);
				end
			end
			MODE_RAMP: begin
				if (ramp_bad) begin
					status = 1'b1;
				end else begin
					kind_nxt         = KIND_RAMP;
					ramp_level_nxt   = {{2{item.level_mv[15]}}, item.level_mv};
					ramp_end_nxt     = item.end_mv;
					ramp_inc_nxt     = inc_fix;
					ramp_period_nxt  = item.span_ticks[12:0];
					ramp_elapsed_nxt = '0;
					sel_nxt          = choice_sel;
					held_nxt         = drive_split(choice_sel, item.level_mv);
				end
			end
			MODE_BIAS: begin
				kind_nxt    = KIND_BIAS;
				found_l_nxt = '0;
				found_r_nxt = '0;
				enter_left  = 1'b1;
			end
			MODE_STOP: begin
				kind_nxt = KIND_IDLE;
			end
			default: begin
			end
		endcase

		if (go_idle) begin
			kind_nxt = KIND_IDLE;
			held_nxt = '0;
		end

		// Start a probe phase: fresh level, settle count and encoder baseline
		if (enter_left || enter_right) begin
			phase_nxt  = enter_right;
			sel_nxt    = enter_right ? SEL_RIGHT : SEL_LEFT;
			probe_nxt  = {1'b0, cfg.probe_start_mv};
			settle_nxt = cfg.probe_settle_ticks;
			base_nxt   = '0;
			held_nxt   = drive_split(enter_right ? SEL_RIGHT : SEL_LEFT,
				signed'({1'b0, cfg.probe_start_mv}));
			clr        = 1'b1;
		end
	end

	always_comb begin
		res.left_drive_mv  = held_nxt.left;
		res.right_drive_mv = held_nxt.right;
		res.active         = (kind_nxt != KIND_IDLE);
		res.status         = status;
		res.clear_counts   = clr;
		res.bias_left_mv   = found_l_nxt;
		res.bias_right_mv  = found_r_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q         <= KIND_IDLE;
			sel_q          <= SEL_BOTH;
			step_level_q   <= '0;
			step_rem_q     <= '0;
			ramp_level_q   <= '0;
			ramp_end_q     <= '0;
			ramp_inc_q     <= '0;
			ramp_period_q  <= '0;
			ramp_elapsed_q <= '0;
			probe_q        <= '0;
			settle_q       <= '0;
			base_q         <= '0;
			phase_q        <= 1'b0;
			found_l_q      <= '0;
			found_r_q      <= '0;
			held_q         <= '0;
		end else if (fire) begin
			kind_q         <= kind_nxt;
			sel_q          <= sel_nxt;
			step_level_q   <= step_level_nxt;
			step_rem_q     <= step_rem_nxt;
			ramp_level_q   <= ramp_level_nxt;
			ramp_end_q     <= ramp_end_nxt;
			ramp_inc_q     <= ramp_inc_nxt;
			ramp_period_q  <= ramp_period_nxt;
			ramp_elapsed_q <= ramp_elapsed_nxt;
			probe_q        <= probe_nxt;
			settle_q       <= settle_nxt;
			base_q         <= base_nxt;
			phase_q        <= phase_nxt;
			found_l_q      <= found_l_nxt;
			found_r_q      <= found_r_nxt;
			held_q         <= held_nxt;
		end
	end

	a_clr_enters_bias: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && clr) |=> (kind_q == KIND_BIAS && base_q == '0))
		else $error("encoder clear without a fresh bias phase");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && status) |=> ($stable(kind_q) && $stable(held_q) && $stable(sel_q)))
		else $error("rejected start changed the running test");

	a_ramp_elapsed: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == KIND_RAMP) |-> (ramp_elapsed_q < ramp_period_q))
		else $error("ramp elapsed count reached its period");

	a_bias_sel: assert property (@(posedge clk) disable iff (!arst_n)
		(kind_q == KIND_BIAS) |->
		((phase_q && sel_q == SEL_RIGHT) || (!phase_q && sel_q == SEL_LEFT)))
		else $error("bias phase and motor selection disagree");

endmodule

`default_nettype wire

// ===== rtl/motor_test_stimulus_sequencer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Motor test stimulus sequencer. Every input transaction is a 1 ms tick, a test start
// (step, ramp or bias search, selected by s_tuser) or a stop, and produces exactly one
// output transaction carrying the left and right drive commands in millivolts, the
// active and rejected-start flags, an encoder clear pulse and the bias search results.
// A start with a bad argument is answered with status set and leaves the running test
// and its drive untouched. One transaction is taken every clock while the result side
// is ready. The input register takes a transaction at the accepting edge; the test state
// update then loads the result register when the transaction advances, which waits while
// an earlier result is still held and not being taken, and m_tvalid shows the new result.
// Both registers keep their data under back-pressure: while a result waits, the input
// register still takes one more transaction, then s_tready drops until the result goes.
// Registers are written through cfg_we/cfg_index/cfg_data and must only be changed
// while no transaction is in flight; indexes past the last register are ignored.
// COUNT_BITS sets how many low bits of the encoder counts take part in the movement
// check.
module motor_test_stimulus_sequencer_core #(
	parameter int COUNT_BITS = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// level_mv[15:0], end_mv[31:16], increment_mv[47:32], span_ticks[63:48],
	// motor_choice[71:64], left_count[103:72], right_count[135:104]
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [mtss_pkg::IN_DATA_W-1:0]       s_tdata,
	// mode[2:0]
	input  wire logic [mtss_pkg::IN_USER_W-1:0]       s_tuser,
	// left_drive_mv[15:0], right_drive_mv[31:16], active[32], status[33],
	// clear_counts[34], bias_left_mv[50:35], bias_right_mv[66:51], zero[71:67]
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [mtss_pkg::OUT_DATA_W-1:0]           m_tdata,
	input  wire logic                                 cfg_we,
	input  wire logic [mtss_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mtss_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import mtss_pkg::*;

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	result_t res_nxt;
	logic    advance;

	// Register file: write in place, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_limit_mv     <= RST_DRIVE_LIMIT;
			cfg_q.probe_start_mv     <= RST_PROBE_START;
			cfg_q.probe_increment_mv <= RST_PROBE_INC;
			cfg_q.probe_max_mv       <= RST_PROBE_MAX;
			cfg_q.probe_settle_ticks <= RST_SETTLE;
			cfg_q.move_threshold     <= RST_MOVE_THRESH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DRIVE_LIMIT: cfg_q.drive_limit_mv     <= cfg_data[14:0];
				REG_PROBE_START: cfg_q.probe_start_mv     <= cfg_data[14:0];
				REG_PROBE_INC:   cfg_q.probe_increment_mv <= cfg_data[14:0];
				REG_PROBE_MAX:   cfg_q.probe_max_mv       <= cfg_data[14:0];
				REG_SETTLE:      cfg_q.probe_settle_ticks <= cfg_data;
				REG_MOVE_THRESH: cfg_q.move_threshold     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the held transaction into the result register once that register is free
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input register: unpack the transaction, hold it while the result side stalls
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.mode         <= s_tuser;
			item_s1.level_mv     <= s_tdata[15:0];
			item_s1.end_mv       <= s_tdata[31:16];
			item_s1.increment_mv <= s_tdata[47:32];
			item_s1.span_ticks   <= s_tdata[63:48];
			item_s1.motor_choice <= s_tdata[71:64];
			item_s1.left_count   <= s_tdata[103:72];
			item_s1.right_count  <= s_tdata[135:104];
		end
	end

	// Test state, updated each time a transaction advances
	mtss_engine #(
		.COUNT_BITS(COUNT_BITS)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (advance),
		.item  (item_s1),
		.cfg   (cfg_q),
		.res   (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register: load on advance, otherwise hold
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {5'b0, res_s2.bias_right_mv, res_s2.bias_left_mv,
		res_s2.clear_counts, res_s2.status, res_s2.active,
		res_s2.right_drive_mv, res_s2.left_drive_mv};

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the motor test sequencer.
// The driver takes planned input transactions from a queue and presents them on the slave
// stream; each one it sees accepted is run through a local model of the sequencer and the
// result it must cause is queued. The monitor pops that queue for every result transaction
// on the master stream and compares it field by field.
// The run opens with a short directed burst at the reset register values, then goes through
// several register settings (extremes included). Each setting gets random step, ramp and
// bias search runs, plus a little noise. Registers are only rewritten once everything has
// drained.
module tb;

	import mtss_pkg::*;

	localparam int COUNT_W      = 32;       // encoder bits used by the movement check
	localparam int CYCLE_LIMIT  = 200_000;  // hard stop, far beyond a healthy run
	localparam int DRAIN_CYCLES = 8;        // pipeline is two deep; leave some margin
	localparam int REPORT_LIMIT = 10;
	localparam int QUIET_FROM   = 800;      // window with no idling on either stream
	localparam int QUIET_TO     = 1400;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [IN_USER_W-1:0]  s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	motor_test_stimulus_sequencer_core #(
		.COUNT_BITS(COUNT_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Local copy of the register file, kept in step with every write
	// ------------------------------------------------------------------
	int unsigned lim_cfg    = 32'(RST_DRIVE_LIMIT);
	int unsigned pstart_cfg = 32'(RST_PROBE_START);
	int unsigned pinc_cfg   = 32'(RST_PROBE_INC);
	int unsigned pmax_cfg   = 32'(RST_PROBE_MAX);
	int unsigned settle_cfg = 32'(RST_SETTLE);
	int unsigned thr_cfg    = 32'(RST_MOVE_THRESH);

	// ------------------------------------------------------------------
	// Sequencer state as the model sees it
	// ------------------------------------------------------------------
	kind_t              seq_kind    = KIND_IDLE;
	logic [1:0]         seq_sel     = SEL_BOTH;
	int                 step_lvl    = 0;
	int unsigned        step_left   = 0;
	int                 ramp_lvl    = 0;
	int                 ramp_stop   = 0;
	int                 ramp_inc    = 0;
	int unsigned        ramp_per    = 0;
	int unsigned        ramp_cnt    = 0;
	int unsigned        probe_lvl   = 0;
	int unsigned        settle_cnt  = 0;
	logic [COUNT_W-1:0] baseline    = '0;
	logic               probe_right = 1'b0;
	int                 found_l     = 0;
	int                 found_r     = 0;
	int                 held_l      = 0;
	int                 held_r      = 0;

	// Bookkeeping
	item_t   pending_items[$];
	result_t expected_results[$];
	item_t   in_flight;
	result_t want_result;
	int      cycle_count     = 0;
	int      items_queued    = 0;
	int      items_accepted  = 0;
	int      results_checked = 0;
	int      mismatches      = 0;
	int      settings_used   = 1;
	int      steps_run       = 0;
	int      ramps_run       = 0;
	int      searches_run    = 0;
	int      starts_rejected = 0;
	int      clear_pulses    = 0;

	// Send a level to whichever motors the running test owns; the other one gets zero
	function automatic void route_level(input int mv);
		case (seq_sel)
			SEL_LEFT: begin
				held_l = mv;
				held_r = 0;
			end
			SEL_RIGHT: begin
				held_l = 0;
				held_r = mv;
			end
			default: begin
				held_l = mv;
				held_r = mv;
			end
		endcase
	endfunction

	function automatic void halt_test();
		seq_kind = KIND_IDLE;
		held_l   = 0;
		held_r   = 0;
	endfunction

	// Begin probing one side from the first probe level, counts freshly cleared
	function automatic void enter_probe(input logic right_side);
		probe_right = right_side;
		seq_sel     = right_side ? SEL_RIGHT : SEL_LEFT;
		probe_lvl   = pstart_cfg;
		settle_cnt  = settle_cfg;
		baseline    = '0;
		route_level(int'(probe_lvl));
	endfunction

	// Advance the running test by one millisecond; returns the encoder clear request
	function automatic logic advance_tick(input item_t it);
		logic [COUNT_W-1:0] now_cnt;
		logic [COUNT_W-1:0] diff;
		logic [COUNT_W-1:0] mag;
		case (seq_kind)
			KIND_STEP: begin
				if (step_left > 0) begin
					step_left--;
					route_level(step_lvl);
				end else begin
					halt_test();
				end
			end
			KIND_RAMP: begin
				ramp_cnt++;
				if (ramp_cnt >= ramp_per) begin
					ramp_cnt = 0;
					ramp_lvl += ramp_inc;
					// drop to idle as soon as the level overshoots the end
					if ((ramp_inc > 0 && ramp_lvl > ramp_stop) ||
							(ramp_inc < 0 && ramp_lvl < ramp_stop)) begin
						halt_test();
						return 1'b0;
					end
				end
				route_level(ramp_lvl);
			end
			KIND_BIAS: begin
				if (settle_cnt > 0) begin
					settle_cnt--;
					route_level(int'(probe_lvl));
					return 1'b0;
				end
				now_cnt = probe_right ? it.right_count[COUNT_W-1:0] : it.left_count[COUNT_W-1:0];
				diff    = now_cnt - baseline;
				mag     = diff[COUNT_W-1] ? -diff : diff;
				if (mag >= thr_cfg) begin
					// wheel moved: record the level, then hand over to the right side or finish
					if (!probe_right) begin
						found_l = int'(probe_lvl);
						enter_probe(1'b1);
						return 1'b1;
					end
					found_r = int'(probe_lvl);
					halt_test();
					return 1'b0;
				end
				probe_lvl += pinc_cfg;
				if (probe_lvl > pmax_cfg) begin
					// nothing moved up to the ceiling: give up on this side
					if (!probe_right) begin
						found_l = -1;
						enter_probe(1'b1);
						return 1'b1;
					end
					found_r = -1;
					halt_test();
					return 1'b0;
				end
				settle_cnt = settle_cfg;
				baseline   = now_cnt;
				route_level(int'(probe_lvl));
			end
			default: halt_test();
		endcase
		return 1'b0;
	endfunction

	// Work out the result transaction caused by one accepted input transaction
	function automatic result_t predict_sequencer(input item_t it);
		result_t     r;
		int          lvl;
		int          stop_lvl;
		int          inc;
		int          lim;
		int unsigned span;
		logic [1:0]  pick;
		logic        rejected;
		logic        pulse;
		lvl      = int'($signed(it.level_mv));
		stop_lvl = int'($signed(it.end_mv));
		inc      = int'($signed(it.increment_mv));
		lim      = int'(lim_cfg);
		span     = 32'(it.span_ticks);
		pick     = (it.motor_choice > 8'd2) ? SEL_BOTH : it.motor_choice[1:0];
		rejected = 1'b0;
		pulse    = 1'b0;
		case (it.mode)
			MODE_TICK: pulse = advance_tick(it);
			MODE_STEP: begin
				if (span == 0 || span > STEP_MAX_TICKS || lvl < -lim || lvl > lim) begin
					rejected = 1'b1;
				end else begin
					seq_kind  = KIND_STEP;
					step_lvl  = lvl;
					step_left = span;
					seq_sel   = pick;
					route_level(lvl);
					steps_run++;
				end
			end
			MODE_RAMP: begin
				if (inc == 0 || span < RAMP_MIN_TICKS || span > RAMP_MAX_TICKS ||
						lvl < -lim || lvl > lim || stop_lvl < -lim || stop_lvl > lim) begin
					rejected = 1'b1;
				end else begin
					// point the increment at the end level; the most negative one saturates
					if ((lvl < stop_lvl && inc < 0) || (lvl > stop_lvl && inc > 0))
						inc = (inc == -32768) ? 32767 : -inc;
					seq_kind  = KIND_RAMP;
					ramp_lvl  = lvl;
					ramp_stop = stop_lvl;
					ramp_inc  = inc;
					ramp_per  = span;
					ramp_cnt  = 0;
					seq_sel   = pick;
					route_level(lvl);
					ramps_run++;
				end
			end
			MODE_BIAS: begin
				seq_kind = KIND_BIAS;
				found_l  = 0;
				found_r  = 0;
				enter_probe(1'b0);
				pulse = 1'b1;
				searches_run++;
			end
			MODE_STOP: seq_kind = KIND_IDLE;
			default: ;
		endcase
		if (rejected)
			starts_rejected++;
		if (pulse)
			clear_pulses++;
		r.left_drive_mv  = held_l[15:0];
		r.right_drive_mv = held_r[15:0];
		r.active         = (seq_kind != KIND_IDLE);
		r.status         = rejected;
		r.clear_counts   = pulse;
		r.bias_left_mv   = found_l[15:0];
		r.bias_right_mv  = found_r[15:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	function automatic void push_item(input item_t it);
		pending_items.push_back(it);
		if (it.mode <= MODE_STOP)
			items_queued++;
	endfunction

	// Every field random; callers overwrite what the run needs
	function automatic item_t random_item(input logic [2:0] md);
		item_t it;
		it.mode         = md;
		it.level_mv     = 16'($urandom);
		it.end_mv       = 16'($urandom);
		it.increment_mv = 16'($urandom);
		it.span_ticks   = 16'($urandom);
		it.motor_choice = 8'($urandom);
		it.left_count   = $urandom;
		it.right_count  = $urandom;
		return it;
	endfunction

	function automatic void plan(input logic [2:0] md, input int lvl, input int endv,
			input int inc, input int span, input int choice);
		item_t it;
		it.mode         = md;
		it.level_mv     = 16'(lvl);
		it.end_mv       = 16'(endv);
		it.increment_mv = 16'(inc);
		it.span_ticks   = 16'(span);
		it.motor_choice = 8'(choice);
		it.left_count   = '0;
		it.right_count  = '0;
		push_item(it);
	endfunction

	// Mostly inside the drive limit, often right on it, now and then anything at all
	function automatic int pick_level();
		int lim;
		int r;
		lim = int'(lim_cfg);
		r   = $urandom_range(0, 99);
		if (r < 70)
			return int'($urandom_range(0, 2 * lim)) - lim;
		if (r < 85)
			return $urandom_range(0, 1) ? lim : -lim;
		return int'($signed(16'($urandom)));
	endfunction

	function automatic int wobble(input int s);
		return int'($urandom_range(0, 4 * s)) - 2 * s;
	endfunction

	function automatic void add_step_run();
		item_t it;
		int    r;
		it          = random_item(MODE_STEP);
		it.level_mv = 16'(pick_level());
		r           = $urandom_range(0, 99);
		if (r < 80)
			it.span_ticks = 16'($urandom_range(1, 12));
		else if (r < 88)
			it.span_ticks = 16'($urandom_range(1, STEP_MAX_TICKS));
		else if (r < 94)
			it.span_ticks = '0;
		else
			it.span_ticks = 16'($urandom_range(STEP_MAX_TICKS + 1, 65535));
		if ($urandom_range(0, 1))
			it.motor_choice = 8'($urandom_range(0, 2));
		push_item(it);
		repeat ($urandom_range(0, 16)) push_item(random_item(MODE_TICK));
		if ($urandom_range(0, 3) == 0)
			push_item(random_item(MODE_STOP));
	endfunction

	// Ramps are kept short: end close to start so they finish within a few periods
	function automatic void add_ramp_run();
		item_t it;
		int    lim;
		int    a;
		int    b;
		int    mag;
		int    r;
		lim = int'(lim_cfg);
		it  = random_item(MODE_RAMP);
		a   = pick_level();
		b   = a + int'($urandom_range(0, 400)) - 200;
		if (b > lim)
			b = lim;
		if (b < -lim)
			b = -lim;
		mag = (a > b ? a - b : b - a) / int'($urandom_range(1, 3)) + 1;
		r   = $urandom_range(0, 99);
		if (r < 6)
			it.increment_mv = 16'sh8000;
		else if (r < 10)
			it.increment_mv = '0;
		else if (r < 88)
			it.increment_mv = 16'($urandom_range(0, 1) ? mag : -mag);
		r = $urandom_range(0, 99);
		if (r < 85)
			it.span_ticks = 16'($urandom_range(RAMP_MIN_TICKS, RAMP_MIN_TICKS + 5));
		else if (r < 90)
			it.span_ticks = RAMP_MAX_TICKS;
		else if (r < 95)
			it.span_ticks = 16'($urandom_range(0, RAMP_MIN_TICKS - 1));
		else
			it.span_ticks = 16'($urandom_range(RAMP_MAX_TICKS + 1, 65535));
		it.level_mv = 16'(a);
		it.end_mv   = 16'(b);
		if ($urandom_range(0, 1))
			it.motor_choice = 8'($urandom_range(0, 2));
		push_item(it);
		repeat ($urandom_range(20, 180)) push_item(random_item(MODE_TICK));
	endfunction

	// Bias search with encoder counts that follow the clear; some runs keep the wheels
	// still so the search runs out of levels
	function automatic void add_bias_run();
		item_t it;
		int    enc_l;
		int    enc_r;
		int    s;
		logic  still;
		enc_l = 0;
		enc_r = 0;
		s     = int'(thr_cfg) + 1;
		still = ($urandom_range(0, 9) < 3);
		push_item(random_item(MODE_BIAS));
		repeat ($urandom_range(4, 120)) begin
			it = random_item(MODE_TICK);
			if (!still) begin
				enc_l += wobble(s);
				enc_r += wobble(s);
			end
			// leave the odd count fully random to hit the sign and top bits
			if ($urandom_range(0, 99) >= 3) begin
				it.left_count  = enc_l;
				it.right_count = enc_r;
			end
			push_item(it);
		end
		if ($urandom_range(0, 3) == 0)
			push_item(random_item(MODE_STOP));
	endfunction

	function automatic void add_random_traffic(input int goal);
		int stop_at;
		int r;
		stop_at = items_queued + goal;
		while (items_queued < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				add_step_run();
			else if (r < 45)
				add_ramp_run();
			else if (r < 80)
				add_bias_run();
			else
				repeat ($urandom_range(1, 4)) push_item(random_item(3'($urandom_range(4, 7))));
		end
	endfunction

	// Hold until every planned transaction has gone in and every result has come back;
	// look between edges so the driver's and monitor's updates have all landed
	task automatic settle_down();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DRIVE_LIMIT: lim_cfg    = 32'(val[14:0]);
			REG_PROBE_START: pstart_cfg = 32'(val[14:0]);
			REG_PROBE_INC:   pinc_cfg   = 32'(val[14:0]);
			REG_PROBE_MAX:   pmax_cfg   = 32'(val[14:0]);
			REG_SETTLE:      settle_cfg = 32'(val);
			REG_MOVE_THRESH: thr_cfg    = 32'(val);
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [15:0] lim, input logic [15:0] start,
			input logic [15:0] inc, input logic [15:0] top, input logic [15:0] settle,
			input logic [15:0] thr);
		write_reg(REG_DRIVE_LIMIT, lim);
		write_reg(REG_PROBE_START, start);
		write_reg(REG_PROBE_INC, inc);
		write_reg(REG_PROBE_MAX, top);
		write_reg(REG_SETTLE, settle);
		write_reg(REG_MOVE_THRESH, thr);
		settings_used++;
	endtask

	// Random idling, switched off for one long stretch of the run
	function automatic logic idle_roll();
		return (cycle_count < QUIET_FROM || cycle_count >= QUIET_TO) &&
			($urandom_range(0, 99) < 6);
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("result %0d: %s expected %0d, got %0d", results_checked, name,
					$signed(want), $signed(got));
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: present the next planned transaction, model each accepted one
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(predict_sequencer(in_flight));
				items_accepted++;
			end
			// only move on once the current transaction is gone
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && !idle_roll()) begin
					in_flight = pending_items.pop_front();
					s_tdata   <= {in_flight.right_count, in_flight.left_count,
						in_flight.motor_choice, in_flight.span_ticks, in_flight.increment_mv,
						in_flight.end_mv, in_flight.level_mv};
					s_tuser   <= in_flight.mode;
					s_tvalid  <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: compare each result transaction with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result transaction %h arrived with nothing predicted", m_tdata);
				end else begin
					want_result = expected_results.pop_front();
					check_field("left_drive_mv", want_result.left_drive_mv, m_tdata[15:0]);
					check_field("right_drive_mv", want_result.right_drive_mv, m_tdata[31:16]);
					check_field("active", 16'(want_result.active), 16'(m_tdata[32]));
					check_field("status", 16'(want_result.status), 16'(m_tdata[33]));
					check_field("clear_counts", 16'(want_result.clear_counts), 16'(m_tdata[34]));
					check_field("bias_left_mv", want_result.bias_left_mv, m_tdata[50:35]);
					check_field("bias_right_mv", want_result.bias_right_mv, m_tdata[66:51]);
					results_checked++;
				end
			end
			m_tready <= !idle_roll();
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d results still awaited", cycle_count,
				expected_results.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed burst at the reset register values (limit 8000, long settle)
		plan(MODE_TICK, 0, 0, 0, 0, 0);                  // idle tick drives zero
		plan(MODE_STEP, 8000, 0, 0, 1, 1);               // level on the limit, left only
		plan(MODE_TICK, 0, 0, 0, 0, 0);
		plan(MODE_TICK, 0, 0, 0, 0, 0);                  // duration spent: back to idle
		plan(MODE_STEP, -8000, 0, 0, 10000, 255);        // longest step, odd choice means both
		plan(MODE_STEP, 8001, 0, 0, 5, 0);               // level beyond limit: rejected
		plan(MODE_STEP, 100, 0, 0, 0, 0);                // zero duration: rejected
		plan(MODE_STEP, -32768, 0, 0, 10001, 2);         // too long: rejected, step runs on
		plan(MODE_TICK, 0, 0, 0, 0, 0);
		plan(MODE_STOP, 0, 0, 0, 0, 0);                  // drive held for this item
		plan(MODE_TICK, 0, 0, 0, 0, 0);                  // now zero
		plan(MODE_RAMP, -8000, 8000, -32768, 50, 2);     // increment saturates on negation
		plan(MODE_RAMP, 0, 100, 0, 50, 0);               // zero increment: rejected
		plan(MODE_RAMP, 0, 100, 10, 49, 0);              // period too short
		plan(MODE_RAMP, 0, 100, 10, 5001, 0);            // period too long
		plan(MODE_RAMP, 0, 8001, 10, 60, 0);             // end beyond limit
		plan(MODE_RAMP, -8001, 0, 10, 60, 0);            // start beyond limit
		plan(3'd5, 0, 0, 0, 0, 0);                       // unused modes are ignored
		plan(3'd6, 32767, -1, 32767, 65535, 255);
		plan(3'd7, -1, 32767, -1, 65535, 255);
		plan(MODE_RAMP, 100, -100, 300, 5000, 1);        // increment sign corrected
		plan(MODE_TICK, 0, 0, 0, 0, 0);
		plan(MODE_BIAS, 0, 0, 0, 0, 0);                  // clears encoders, probes left
		plan(MODE_TICK, 0, 0, 0, 0, 0);
		plan(MODE_STOP, 0, 0, 0, 0, 0);
		settle_down();

		// Widest limit, tiny search, no settle and a zero threshold: movement at once
		apply_setting(16'd32767, 16'd0, 16'd1, 16'd6, 16'd0, 16'd0);
		add_random_traffic(450);
		settle_down();

		// Limit written with only the spare top bit set, i.e. zero; largest probe values
		apply_setting(16'h8000, 16'd32767, 16'd32767, 16'd32767, 16'd1, 16'd65535);
		add_random_traffic(300);
		settle_down();

		// Longest settle: a bias search never gets past its first level
		apply_setting(16'd12000, 16'd500, 16'd250, 16'd1500, 16'd65535, 16'd8);
		add_random_traffic(150);
		settle_down();

		// Random setting; pause half way until every result is back, then carry on
		apply_setting(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 3000)),
			16'($urandom_range(1, 1000)), 16'($urandom_range(3000, 6000)),
			16'($urandom_range(0, 4)), 16'($urandom_range(1, 60)));
		add_random_traffic(225);
		settle_down();
		add_random_traffic(225);
		settle_down();

		// Ordinary working values
		apply_setting(16'd8000, 16'd1000, 16'd400, 16'd3000, 16'd2, 16'd25);
		add_random_traffic(450);
		settle_down();

		mismatches += expected_results.size();
		$display("checked %0d results from %0d transactions over %0d register settings",
			results_checked, items_accepted, settings_used);
		$display("started %0d steps, %0d ramps, %0d bias searches; %0d starts refused, %0d clears",
			steps_run, ramps_run, searches_run, starts_rejected, clear_pulses);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/mtss_pkg.sv
rtl/mtss_move_det.sv
rtl/mtss_engine.sv
rtl/motor_test_stimulus_sequencer_core.sv
test/tb.sv
